>>> hdl/fsc_pkg.sv
// fsc_pkg: shared constants, types and constant-table builders for the cycloid swing-foot block
// depends on nothing; used by fsc_div and foot_swing_cycloid

package fsc_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SIN_AW           = $clog2(SINE_TABLE_DEPTH);

  // register indexes on the configuration port
  localparam logic [1:0] REG_STEP_LENGTH  = 2'd0;
  localparam logic [1:0] REG_STEP_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_SWING_PERIOD = 2'd2;

  // pipeline shape
  localparam int DIV_STEPS = 16;             // two quotient bits per stage
  localparam int DIV_LAT   = DIV_STEPS + 1;  // front stage plus digit stages
  localparam int FRONT_LAT = 7;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

  localparam logic [63:0]        TWO_PI_Q30     = 64'd6746518852;
  localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
  localparam logic signed [22:0] PI_Q20         = 23'sd3294199;
  localparam logic signed [20:0] MICRO          = 21'sd1000000;

  typedef logic signed [17:0] trig_t;
  typedef trig_t trig_tab_t [SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [31:0] quo;
    logic        ovf;
    logic        neg;
  } div_res_t;

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] r;
    half = 64'd1 << (n - 1);
    mag  = v[63] ? 64'(-v) : 64'(v);
    r    = (mag + half) >> n;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // sine of a q32 turn angle, q16 result, taylor series through x^11
  function automatic trig_t sine_turn(input logic [31:0] t);
    logic [1:0]  q;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    trig_t       v;
    q = t[31:30];
    f = {34'd0, t[29:0]};
    if (q[0]) f = (64'd1 << 30) - f;
    x    = (f * TWO_PI_Q30 + (64'd1 << 31)) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    v = $signed(r[17:0]);
    return q[1] ? -v : v;
  endfunction

  function automatic trig_tab_t build_tab(input logic cosine);
    trig_tab_t   tab;
    logic [31:0] t;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t = 32'(k) << (32 - SIN_AW);
      if (cosine) t = t + 32'h4000_0000;
      tab[k] = sine_turn(t);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_tab(1'b1);

endpackage

>>> hdl/fsc_in_if.sv
// fsc_in_if: request channel into the swing-foot block, phase and lift-off x
// depends on nothing

interface fsc_in_if;
  logic               valid;
  logic               ready;
  logic        [16:0] phase;
  logic signed [17:0] start_pos;

  modport source (output valid, phase, start_pos, input ready);
  modport sink   (input valid, phase, start_pos, output ready);
endinterface

>>> hdl/fsc_out_if.sv
// fsc_out_if: result channel out of the swing-foot block, position and velocity
// depends on nothing

interface fsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x;
  logic        [15:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               vel_valid;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, vel_valid, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, vel_valid, output ready);
endinterface

>>> hdl/fsc_div.sv
// fsc_div: pipelined rounding divide of a magnitude by period * 2^16, radix-4 restoring
// depends on fsc_pkg; instantiated twice by foot_swing_cycloid

module fsc_div (
  input  logic               clk,
  input  logic               en,
  input  logic        [54:0] mag,
  input  logic               neg,
  input  logic        [23:0] period,
  output fsc_pkg::div_res_t  res
);

  logic [55:0] sum;
  logic [39:0] numr;

  logic [23:0] rem [fsc_pkg::DIV_STEPS+1];
  logic [31:0] lo  [fsc_pkg::DIV_STEPS+1];
  logic [31:0] qt  [fsc_pkg::DIV_STEPS+1];
  logic        ovf [fsc_pkg::DIV_STEPS+1];
  logic        sg  [fsc_pkg::DIV_STEPS+1];

  // half the divisor added, then the 2^16 part of the divisor taken off by a shift
  assign sum  = {1'b0, mag} + {17'd0, period, 15'd0};
  assign numr = sum[55:16];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {16'd0, numr[39:32]};
      lo[0]  <= numr[31:0];
      qt[0]  <= '0;
      ovf[0] <= ({16'd0, numr[39:32]} >= period);
      sg[0]  <= neg;
    end
  end

  for (genvar j = 0; j < fsc_pkg::DIV_STEPS; j++) begin : g_step
    logic [24:0] r1;
    logic [24:0] r1s;
    logic [24:0] r2;
    logic [24:0] r2s;
    logic        b1;
    logic        b2;

    always_comb begin
      r1  = {rem[j], lo[j][31]};
      b1  = (r1 >= {1'b0, period});
      r1s = b1 ? r1 - {1'b0, period} : r1;
      r2  = {r1s[23:0], lo[j][30]};
      b2  = (r2 >= {1'b0, period});
      r2s = b2 ? r2 - {1'b0, period} : r2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= r2s[23:0];
        lo[j+1]  <= {lo[j][29:0], 2'b00};
        qt[j+1]  <= {qt[j][29:0], b1, b2};
        ovf[j+1] <= ovf[j];
        sg[j+1]  <= sg[j];
      end
    end
  end

  assign res.quo = qt[fsc_pkg::DIV_STEPS];
  assign res.ovf = ovf[fsc_pkg::DIV_STEPS];
  assign res.neg = sg[fsc_pkg::DIV_STEPS];

endmodule

>>> hdl/foot_swing_cycloid.sv
// foot_swing_cycloid: cycloid swing-foot position and velocity, one result per request
// depends on fsc_pkg, fsc_in_if, fsc_out_if and fsc_div
//
//   channel   dir  handshake      payload
//   sample    in   valid/ready    phase[16:0], start_pos[17:0]
//   result    out  valid/ready    pos_x[18:0], pos_y[15:0], vel_x, vel_y, vel_valid
//   cfg       in   cfg_we         cfg_index[1:0], cfg_data[23:0]
//
// one request per cycle while the output is not stalled; table read, multipliers and rounding
// run over seven stages, then the 17-stage velocity divider and the output register.
// rst (synchronous) clears the stage valid bits and the configuration registers to zero.
// a stalled output freezes the whole pipeline; sample.ready drops with it.

module foot_swing_cycloid (
  input  logic             clk,
  input  logic             rst,
  fsc_in_if.sink           sample,
  fsc_out_if.source        result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  localparam int LAT = fsc_pkg::PIPE_LAT;
  localparam int DL  = fsc_pkg::DIV_LAT;
  localparam int AW  = fsc_pkg::SIN_AW;

  logic signed [17:0] stride_len;
  logic        [15:0] lift_ht;
  logic        [23:0] swing_period_us;

  logic           en;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_len      <= '0;
      lift_ht         <= '0;
      swing_period_us <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsc_pkg::REG_STEP_LENGTH:  stride_len      <= $signed(cfg_data[17:0]);
        fsc_pkg::REG_STEP_HEIGHT:  lift_ht         <= cfg_data[15:0];
        fsc_pkg::REG_SWING_PERIOD: swing_period_us <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en           = !vld[LAT-1] || result.ready;
  assign sample.ready = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  // stage 1: table index
  logic [AW+17:0]     kw;
  logic [AW-1:0]      k1;
  logic [16:0]        ph1, ph2, ph3;
  logic signed [17:0] st1, st2, st3, st4, st5;

  assign kw = {1'b0, sample.phase, {AW{1'b0}}} + (AW+18)'(32768);

  // stage 2: table read
  fsc_pkg::trig_t s2, c2;

  // stage 3: first products
  logic signed [18:0] omc;
  logic signed [48:0] m1_3;
  logic        [33:0] mh3;
  logic signed [36:0] ma3;
  logic signed [34:0] mhs3;

  assign omc = 19'sd65536 - 19'(c2);

  // stage 4
  logic signed [63:0] pyr;
  logic signed [34:0] g4;
  logic        [15:0] py4, py5, py6, py7;
  logic signed [57:0] b1_4;
  logic signed [56:0] am4;

  function automatic logic signed [63:0] rnd_in_py(input logic [33:0] v);
    return fsc_pkg::rnd_shr($signed({30'd0, v}), 17);
  endfunction

  assign pyr = rnd_in_py(mh3);

  // stage 5
  logic signed [52:0] pg5;
  logic signed [37:0] b5;
  logic               aneg5, aneg6, aneg7;
  logic        [54:0] amag5, amag6, amag7;

  // stage 6
  logic signed [63:0] pxs;
  logic signed [18:0] px6, px7;
  logic signed [58:0] bm6;

  assign pxs = 64'(st5) + fsc_pkg::rnd_shr(64'(pg5), 32);

  // stage 7
  logic               bneg7;
  logic        [54:0] bmag7;

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= kw[AW+15:16];
      ph1  <= sample.phase;
      st1  <= sample.start_pos;

      s2   <= fsc_pkg::SIN_TAB[k1];
      c2   <= fsc_pkg::COS_TAB[k1];
      ph2  <= ph1;
      st2  <= st1;

      m1_3 <= 49'(s2) * 49'(fsc_pkg::INV_TWO_PI_Q32);
      mh3  <= 34'(lift_ht) * 34'(omc[17:0]);
      ma3  <= 37'(stride_len) * 37'(omc);
      mhs3 <= 35'($signed({1'b0, lift_ht})) * 35'(s2);
      ph3  <= ph2;
      st3  <= st2;

      g4   <= $signed({2'b00, ph3, 16'd0}) - 35'(fsc_pkg::rnd_shr(64'(m1_3), 16));
      py4  <= (pyr > 64'sd65535) ? 16'hFFFF : pyr[15:0];
      b1_4 <= 58'(mhs3) * 58'(fsc_pkg::PI_Q20);
      am4  <= 57'(ma3) * 57'(fsc_pkg::MICRO);
      st4  <= st3;

      pg5   <= 53'(stride_len) * 53'(g4);
      b5    <= 38'(fsc_pkg::rnd_shr(64'(b1_4), 20));
      aneg5 <= am4[56];
      amag5 <= am4[56] ? 55'(-am4) : 55'(am4);
      st5   <= st4;
      py5   <= py4;

      if (pxs > 64'sd262143) begin
        px6 <= 19'sh3FFFF;
      end else if (pxs < -64'sd262144) begin
        px6 <= 19'sh40000;
      end else begin
        px6 <= pxs[18:0];
      end
      bm6   <= 59'(b5) * 59'(fsc_pkg::MICRO);
      aneg6 <= aneg5;
      amag6 <= amag5;
      py6   <= py5;

      bneg7 <= bm6[58];
      bmag7 <= bm6[58] ? 55'(-bm6) : 55'(bm6);
      aneg7 <= aneg6;
      amag7 <= amag6;
      px7   <= px6;
      py7   <= py6;
    end
  end

  fsc_pkg::div_res_t dva, dvb;

  fsc_div u_div_x (
    .clk    (clk),
    .en     (en),
    .mag    (amag7),
    .neg    (aneg7),
    .period (swing_period_us),
    .res    (dva)
  );

  fsc_div u_div_y (
    .clk    (clk),
    .en     (en),
    .mag    (bmag7),
    .neg    (bneg7),
    .period (swing_period_us),
    .res    (dvb)
  );

  // positions wait alongside the divider
  logic signed [18:0] pxd [DL];
  logic        [15:0] pyd [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      pxd[0] <= px7;
      pyd[0] <= py7;
      for (int i = 1; i < DL; i++) begin
        pxd[i] <= pxd[i-1];
        pyd[i] <= pyd[i-1];
      end
    end
  end

  function automatic logic [31:0] vel_sat(input fsc_pkg::div_res_t r, input logic zero);
    if (zero) return 32'd0;
    if (r.ovf) return r.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (!r.neg) return r.quo[31] ? 32'h7FFF_FFFF : r.quo;
    return (r.quo > 32'h8000_0000) ? 32'h8000_0000 : -r.quo;
  endfunction

  logic pzero;
  assign pzero = (swing_period_us == 24'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      result.pos_x     <= pxd[DL-1];
      result.pos_y     <= pyd[DL-1];
      result.vel_x     <= $signed(vel_sat(dva, pzero));
      result.vel_y     <= $signed(vel_sat(dvb, pzero));
      result.vel_valid <= !pzero;
    end
  end

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for foot_swing_cycloid, cycloid swing-foot position and velocity
// depends on fsc_pkg, fsc_in_if, fsc_out_if and foot_swing_cycloid

`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 2000;
  // index with no register behind it
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [18:0] pos_x;
    logic        [15:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               vel_valid;
  } foot_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = fsc_pkg::REG_STEP_LENGTH;
  logic [23:0] cfg_data = '0;

  fsc_in_if sample ();
  fsc_out_if result ();

  foot_swing_cycloid DUT (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic signed [63:0] cur_length = 0;
  logic [63:0] cur_height = 0;
  logic [63:0] cur_period = 0;

  foot_state_t expected_q[$];
  bit failed = 0;
  bit quiet = 0;
  int stall_burst = 0;
  int idle_cnt = 0;

  initial begin
    sample.valid = 1'b0;
    sample.phase = '0;
    sample.start_pos = '0;
    result.ready = 1'b0;
  end

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int n);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] round_div(input logic signed [63:0] n,
                                                   input logic [63:0] d);
    logic [63:0] m;
    m = n < 0 ? -n : n;
    m = (m + d / 2) / d;
    return n < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // q16 sine of a q32 turn angle
  function automatic logic signed [63:0] turn_sine(input logic [31:0] t);
    logic [63:0] f, x, x2, term, sum, r;
    f = {34'd0, t[29:0]};
    if (t[30]) f = (64'd1 << 30) - f;
    x = (f * 64'd6746518852 + (64'd1 << 31)) >> 32;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return t[31] ? -$signed(r) : $signed(r);
  endfunction

  function automatic foot_state_t foot_predict(input logic [16:0] ph,
                                               input logic signed [17:0] st);
    logic [63:0] k;
    logic [31:0] t;
    logic signed [63:0] s, c, g, a, b;
    foot_state_t r;
    k = ((64'(ph) * fsc_pkg::SINE_TABLE_DEPTH + 32768) >> 16) % fsc_pkg::SINE_TABLE_DEPTH;
    t = 32'((k << 32) / fsc_pkg::SINE_TABLE_DEPTH);
    s = turn_sine(t);
    c = turn_sine(t + 32'h4000_0000);
    g = ($signed(64'(ph)) <<< 16) - round_shift(s * 64'sd683565276, 16);
    r.pos_x = 19'(clamp(64'(st) + round_shift(cur_length * g, 32), -262144, 262143));
    r.pos_y = 16'(clamp(round_shift($signed(cur_height) * (65536 - c), 17), 0, 65535));
    r.vel_x = '0;
    r.vel_y = '0;
    r.vel_valid = 1'b0;
    if (cur_period != 0) begin
      a = cur_length * (65536 - c);
      b = round_shift($signed(cur_height) * s * 64'sd3294199, 20);
      r.vel_x = 32'(clamp(round_div(a * 1000000, cur_period << 16),
                          -64'sd2147483648, 64'sd2147483647));
      r.vel_y = 32'(clamp(round_div(b * 1000000, cur_period << 16),
                          -64'sd2147483648, 64'sd2147483647));
      r.vel_valid = 1'b1;
    end
    return r;
  endfunction

  // receiver side: random stall bursts and the result check
  always @(posedge clk) begin
    foot_state_t got, want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        got = '{result.pos_x, result.pos_y, result.vel_x, result.vel_y, result.vel_valid};
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          failed = 1;
        end else begin
          want = expected_q.pop_front();
          if (got.pos_x !== want.pos_x)
            $display("%0t pos_x exp %0d got %0d", $time, want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y)
            $display("%0t pos_y exp %0d got %0d", $time, want.pos_y, got.pos_y);
          if (got.vel_x !== want.vel_x)
            $display("%0t vel_x exp %0d got %0d", $time, want.vel_x, got.vel_x);
          if (got.vel_y !== want.vel_y)
            $display("%0t vel_y exp %0d got %0d", $time, want.vel_y, got.vel_y);
          if (got.vel_valid !== want.vel_valid)
            $display("%0t vel_valid exp %0b got %0b", $time, want.vel_valid, got.vel_valid);
          if (got !== want) failed = 1;
        end
      end
      if (stall_burst > 0) begin
        stall_burst--;
        result.ready <= 1'b0;
      end else if (!quiet && $urandom_range(9) == 0) begin
        stall_burst = $urandom_range(17, 1) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || rst)
      idle_cnt <= 0;
    else if (idle_cnt >= LIMIT) begin
      $display("FAIL foot_swing_cycloid");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  // one write with the enable raised, then the enable is lowered again before return
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fsc_pkg::REG_STEP_LENGTH:  cur_length = $signed(val[17:0]);
      fsc_pkg::REG_STEP_HEIGHT:  cur_height = val[15:0];
      fsc_pkg::REG_SWING_PERIOD: cur_period = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // waits for the pipeline to empty before a register change
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (fsc_pkg::PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic send_request(input logic [16:0] ph, input logic signed [17:0] st);
    if (!quiet && $urandom_range(7) == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.phase <= ph;
    sample.start_pos <= st;
    do @(posedge clk); while (!sample.ready);
    expected_q.push_back(foot_predict(ph, st));
  endtask

  task automatic finish_burst();
    sample.valid <= 1'b0;
    drain();
  endtask

  task automatic test_zero_period();
    write_reg(fsc_pkg::REG_STEP_LENGTH, 24'h01FFFF);
    write_reg(fsc_pkg::REG_STEP_HEIGHT, 24'hFFFF);
    write_reg(fsc_pkg::REG_SWING_PERIOD, 24'd0);
    send_request(17'd0, -18'sd131072);
    send_request(17'd16384, 18'sd131071);
    send_request(17'd32768, 18'sd0);
    send_request(17'd65536, 18'sd131071);
    send_request(17'h1FFFF, -18'sd131072);
    finish_burst();
  endtask

  task automatic test_extremes();
    logic [16:0] phases[8] = '{0, 1, 32, 16384, 32768, 49152, 65535, 65536};
    write_reg(fsc_pkg::REG_STEP_LENGTH, 24'h020000);
    write_reg(fsc_pkg::REG_STEP_HEIGHT, 24'hFFFF);
    write_reg(fsc_pkg::REG_SWING_PERIOD, 24'd1);
    foreach (phases[i]) send_request(phases[i], (i % 2) ? 18'sd131071 : -18'sd131072);
    send_request(17'h1FFFF, 18'sd131071);
    finish_burst();
    write_reg(fsc_pkg::REG_STEP_LENGTH, 24'h01FFFF);
    write_reg(fsc_pkg::REG_STEP_HEIGHT, 24'd0);
    write_reg(fsc_pkg::REG_SWING_PERIOD, 24'hFFFFFF);
    write_reg(REG_UNMAPPED, 24'h123456);  // ignored, registers keep their values
    foreach (phases[i]) send_request(phases[i], 18'sd0);
    finish_burst();
  endtask

  task automatic test_random(input int n);
    for (int p = 0; p < 8; p++) begin
      write_reg(fsc_pkg::REG_STEP_LENGTH, 24'($urandom));
      write_reg(fsc_pkg::REG_STEP_HEIGHT, 24'($urandom));
      case ($urandom_range(3))
        0: write_reg(fsc_pkg::REG_SWING_PERIOD, 24'($urandom_range(1000)));
        1: write_reg(fsc_pkg::REG_SWING_PERIOD, 24'd0);
        default: write_reg(fsc_pkg::REG_SWING_PERIOD, 24'($urandom));
      endcase
      if (p == 7) quiet = 1;
      for (int i = 0; i < n / 8; i++)
        send_request($urandom_range(9) == 0 ? 17'($urandom) : 17'($urandom_range(65536)),
                     18'($urandom));
      finish_burst();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_period();
    test_extremes();
    test_random(2000);
    if (!failed)
      $display("PASS foot_swing_cycloid");
    else
      $display("FAIL foot_swing_cycloid");
    $finish;
  end

endmodule
